FILE: src/jtsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtsp_pkg
// Shared codes of the JSON token structure parser: token, event, error and
// parser state encodings, plus stream beat widths.
// ----------------------------------------------------------------------------
package jtsp_pkg;

  // input beat and result beat widths
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned DepthW   = 7;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ALLOW_MULTIPLE = 2'd0,
    CFG_ALLOW_TRAILING = 2'd1,
    CFG_ALLOW_PARTIAL  = 2'd2
  } cfg_idx_e;

  // lexed token codes (14 and 15 carry no meaning)
  typedef enum logic [3:0] {
    TOK_STRING  = 4'd0,
    TOK_TRUE    = 4'd1,
    TOK_FALSE   = 4'd2,
    TOK_NULL    = 4'd3,
    TOK_INTEGER = 4'd4,
    TOK_DOUBLE  = 4'd5,
    TOK_MAP_OPEN  = 4'd6,
    TOK_MAP_CLOSE = 4'd7,
    TOK_ARR_OPEN  = 4'd8,
    TOK_ARR_CLOSE = 4'd9,
    TOK_COLON   = 4'd10,
    TOK_COMMA   = 4'd11,
    TOK_LEX_ERR = 4'd12,
    TOK_END     = 4'd13
  } token_e;

  // structural events
  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_STRING    = 4'd1,
    EV_TRUE      = 4'd2,
    EV_FALSE     = 4'd3,
    EV_NULL      = 4'd4,
    EV_INTEGER   = 4'd5,
    EV_DOUBLE    = 4'd6,
    EV_KEY       = 4'd7,
    EV_MAP_START = 4'd8,
    EV_MAP_END   = 4'd9,
    EV_ARR_START = 4'd10,
    EV_ARR_END   = 4'd11,
    EV_DONE      = 4'd12
  } event_e;

  // error codes
  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_LEXICAL    = 4'd1,
    ERR_UNALLOWED  = 4'd2,
    ERR_BAD_KEY    = 4'd3,
    ERR_NO_COLON   = 4'd4,
    ERR_AFTER_MAPV = 4'd5,
    ERR_AFTER_ELEM = 4'd6,
    ERR_TRAILING   = 4'd7,
    ERR_PREMATURE  = 4'd8,
    ERR_NUM_RANGE  = 4'd9,
    ERR_TOO_DEEP   = 4'd10
  } error_e;

  // parser state of one nesting level
  typedef enum logic [3:0] {
    ST_START        = 4'd0,
    ST_GOT_VALUE    = 4'd1,
    ST_COMPLETE     = 4'd2,
    ST_MAP_START    = 4'd3,
    ST_MAP_NEED_KEY = 4'd4,
    ST_MAP_SEP      = 4'd5,
    ST_MAP_NEED_VAL = 4'd6,
    ST_MAP_GOT_VAL  = 4'd7,
    ST_ARR_START    = 4'd8,
    ST_ARR_NEED_VAL = 4'd9,
    ST_ARR_GOT_VAL  = 4'd10
  } pstate_e;

endpackage

FILE: src/json_token_structure_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_token_structure_parser_top
// Checks the structure of a lexed JSON token stream with a pushdown stack of
// parser states and reports one event, status, error code and depth per token.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents (lsb first)
//  s_axis    in   token[3:0], number_out_of_range[4], zero pad [7:5]
//  m_axis    out  event_res[3:0], status[4], error_code[8:5], nesting_depth[15:9]
//  cfg       in   cfg_addr_i selects register, cfg_data_i bit 0 is written
//
//  One token per cycle while results are taken; each result appears in the cycle after its token beat.
//  The top state and the entry under it are kept in flops, so a pop needs no
//  memory read in the cycle of the token; the stack RAM read is registered.
//  The input side stalls only while a result waits and m_axis_tready_i is low.
//  Reset (rst_ni low) clears state, depth, error and configuration; the stack
//  RAM is not cleared, entries are only read after being pushed.
// ----------------------------------------------------------------------------
module json_token_structure_parser_top #(
  parameter int unsigned MAX_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // token beats: token[3:0], number_out_of_range[4]
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [jtsp_pkg::InDataW-1:0]  s_axis_tdata_i,
  // result beats: event_res[3:0], status[4], error_code[8:5], nesting_depth[15:9]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [jtsp_pkg::OutDataW-1:0] m_axis_tdata_o,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic        cfg_data_i
);

  localparam int unsigned SpW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  // configuration flags
  logic allow_mult_q, allow_trail_q, allow_part_q;

  // parser state
  jtsp_pkg::pstate_e top_q, top_d;
  jtsp_pkg::pstate_e under_q;
  jtsp_pkg::pstate_e push_val;
  jtsp_pkg::pstate_e st_eff, adv_st;
  jtsp_pkg::pstate_e stack_mem [MAX_DEPTH];
  logic [SpW-1:0]    sp_q, sp_d;
  logic [3:0]        err_q, err_d;
  logic              push, pop;
  logic [AW-1:0]     rd_addr, wr_addr;

  // output register
  logic                          out_valid_q;
  logic [jtsp_pkg::OutDataW-1:0] out_data_q;
  logic [3:0]                    ev;
  logic                          accept;

  logic [3:0] tok;
  logic       rng;

  assign tok = s_axis_tdata_i[3:0];
  assign rng = s_axis_tdata_i[4];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_mult_q  <= 1'b0;
      allow_trail_q <= 1'b0;
      allow_part_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        jtsp_pkg::CFG_ALLOW_MULTIPLE: allow_mult_q  <= cfg_data_i;
        jtsp_pkg::CFG_ALLOW_TRAILING: allow_trail_q <= cfg_data_i;
        jtsp_pkg::CFG_ALLOW_PARTIAL:  allow_part_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a finished text may restart as a new top-level value
  assign st_eff = (top_q == jtsp_pkg::ST_COMPLETE && allow_mult_q) ?
                  jtsp_pkg::ST_GOT_VALUE : top_q;

  // level state after a value is taken
  always_comb begin
    if (st_eff == jtsp_pkg::ST_START || st_eff == jtsp_pkg::ST_GOT_VALUE) begin
      adv_st = jtsp_pkg::ST_COMPLETE;
    end else if (st_eff == jtsp_pkg::ST_MAP_NEED_VAL) begin
      adv_st = jtsp_pkg::ST_MAP_GOT_VAL;
    end else begin
      adv_st = jtsp_pkg::ST_ARR_GOT_VAL;
    end
  end

  // token check and stack update
  always_comb begin
    top_d    = top_q;
    sp_d     = sp_q;
    err_d    = err_q;
    ev       = jtsp_pkg::EV_NONE;
    push     = 1'b0;
    pop      = 1'b0;
    push_val = adv_st;

    if (err_q == jtsp_pkg::ERR_NONE) begin
      if (tok == jtsp_pkg::TOK_END) begin
        if (top_q == jtsp_pkg::ST_COMPLETE || top_q == jtsp_pkg::ST_GOT_VALUE ||
            allow_part_q) begin
          ev = jtsp_pkg::EV_DONE;
        end else begin
          err_d = jtsp_pkg::ERR_PREMATURE;
        end
      end else begin
        top_d = st_eff;
        case (st_eff)
          jtsp_pkg::ST_COMPLETE: begin
            if (!allow_trail_q) err_d = jtsp_pkg::ERR_TRAILING;
          end
          jtsp_pkg::ST_MAP_START, jtsp_pkg::ST_MAP_NEED_KEY: begin
            if (tok == jtsp_pkg::TOK_LEX_ERR) begin
              err_d = jtsp_pkg::ERR_LEXICAL;
            end else if (tok == jtsp_pkg::TOK_STRING) begin
              top_d = jtsp_pkg::ST_MAP_SEP;
              ev    = jtsp_pkg::EV_KEY;
            end else if (tok == jtsp_pkg::TOK_MAP_CLOSE &&
                         st_eff == jtsp_pkg::ST_MAP_START) begin
              pop = 1'b1;
              ev  = jtsp_pkg::EV_MAP_END;
            end else begin
              err_d = jtsp_pkg::ERR_BAD_KEY;
            end
          end
          jtsp_pkg::ST_MAP_SEP: begin
            if (tok == jtsp_pkg::TOK_COLON) top_d = jtsp_pkg::ST_MAP_NEED_VAL;
            else if (tok == jtsp_pkg::TOK_LEX_ERR) err_d = jtsp_pkg::ERR_LEXICAL;
            else err_d = jtsp_pkg::ERR_NO_COLON;
          end
          jtsp_pkg::ST_MAP_GOT_VAL: begin
            if (tok == jtsp_pkg::TOK_MAP_CLOSE) begin
              pop = 1'b1;
              ev  = jtsp_pkg::EV_MAP_END;
            end else if (tok == jtsp_pkg::TOK_COMMA) begin
              top_d = jtsp_pkg::ST_MAP_NEED_KEY;
            end else if (tok == jtsp_pkg::TOK_LEX_ERR) begin
              err_d = jtsp_pkg::ERR_LEXICAL;
            end else begin
              err_d = jtsp_pkg::ERR_AFTER_MAPV;
            end
          end
          jtsp_pkg::ST_ARR_GOT_VAL: begin
            if (tok == jtsp_pkg::TOK_ARR_CLOSE) begin
              pop = 1'b1;
              ev  = jtsp_pkg::EV_ARR_END;
            end else if (tok == jtsp_pkg::TOK_COMMA) begin
              top_d = jtsp_pkg::ST_ARR_NEED_VAL;
            end else if (tok == jtsp_pkg::TOK_LEX_ERR) begin
              err_d = jtsp_pkg::ERR_LEXICAL;
            end else begin
              err_d = jtsp_pkg::ERR_AFTER_ELEM;
            end
          end
          default: begin
            // a value is expected here
            if (tok == jtsp_pkg::TOK_LEX_ERR) begin
              err_d = jtsp_pkg::ERR_LEXICAL;
            end else if (tok <= jtsp_pkg::TOK_DOUBLE) begin
              if ((tok == jtsp_pkg::TOK_INTEGER || tok == jtsp_pkg::TOK_DOUBLE) && rng) begin
                err_d = jtsp_pkg::ERR_NUM_RANGE;
              end else begin
                top_d = adv_st;
                ev    = 4'(tok + 4'd1);
              end
            end else if (tok == jtsp_pkg::TOK_MAP_OPEN || tok == jtsp_pkg::TOK_ARR_OPEN) begin
              if (sp_q >= SpW'(MAX_DEPTH)) begin
                err_d = jtsp_pkg::ERR_TOO_DEEP;
              end else begin
                push = 1'b1;
                sp_d = sp_q + 1'b1;
                if (tok == jtsp_pkg::TOK_MAP_OPEN) begin
                  top_d = jtsp_pkg::ST_MAP_START;
                  ev    = jtsp_pkg::EV_MAP_START;
                end else begin
                  top_d = jtsp_pkg::ST_ARR_START;
                  ev    = jtsp_pkg::EV_ARR_START;
                end
              end
            end else if (tok == jtsp_pkg::TOK_ARR_CLOSE &&
                         st_eff == jtsp_pkg::ST_ARR_START) begin
              pop = 1'b1;
              ev  = jtsp_pkg::EV_ARR_END;
            end else begin
              err_d = jtsp_pkg::ERR_UNALLOWED;
            end
          end
        endcase

        // closing a level returns to the saved state underneath
        if (pop) begin
          if (sp_q != '0) begin
            sp_d  = sp_q - 1'b1;
            top_d = under_q;
          end else begin
            top_d = jtsp_pkg::ST_COMPLETE;
          end
        end
      end
    end

    if (err_d != jtsp_pkg::ERR_NONE) ev = jtsp_pkg::EV_NONE;
  end

  assign wr_addr = AW'(sp_q);
  assign rd_addr = AW'(sp_d - 1'b1);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= jtsp_pkg::ST_START;
      sp_q  <= '0;
      err_q <= jtsp_pkg::ERR_NONE;
    end else if (accept) begin
      top_q <= top_d;
      sp_q  <= sp_d;
      err_q <= err_d;
    end
  end

  // stack ram and cached entry under the top
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (push) begin
        stack_mem[wr_addr] <= push_val;
        under_q            <= push_val;
      end else begin
        under_q <= stack_mem[rd_addr];
      end
    end
  end

  // result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {jtsp_pkg::DepthW'(sp_d), err_d, (err_d != jtsp_pkg::ERR_NONE), ev};
    end
  end

endmodule

FILE: src/jtsp_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtsp_chk
// Port-level checks of the JSON token structure parser: result consistency,
// sticky errors, depth steps and stalled result beats.
// ----------------------------------------------------------------------------
module jtsp_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [jtsp_pkg::OutDataW-1:0] m_axis_tdata_o
);

  logic       out_beat;
  logic       err_seen_q;
  logic [6:0] depth_q;
  logic [6:0] depth;

  assign out_beat = m_axis_tvalid_o && m_axis_tready_i;
  assign depth    = m_axis_tdata_o[15:9];

  // error seen on an earlier beat and last reported depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
      depth_q    <= '0;
    end else if (out_beat) begin
      err_seen_q <= err_seen_q || m_axis_tdata_o[4];
      depth_q    <= depth;
    end
  end

  // an error beat carries no event
  a_err_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[4] |-> m_axis_tdata_o[3:0] == jtsp_pkg::EV_NONE)
    else $error("error beat carries an event");

  // status and error code agree
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[4] == (m_axis_tdata_o[8:5] != jtsp_pkg::ERR_NONE))
    else $error("status disagrees with error code");

  // errors stay until reset
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && err_seen_q |-> m_axis_tdata_o[4])
    else $error("recorded error was lost");

  // depth moves by at most one level per beat
  a_depth_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (depth == depth_q) || (depth == 7'(depth_q + 7'd1)) ||
                        (depth == 7'(depth_q - 7'd1)))
    else $error("nesting depth jumped");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result beat changed");

endmodule

bind json_token_structure_parser_top jtsp_chk u_jtsp_chk (.*);
